// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property sampled on the rising clock edge, off while reset is asserted.
`define ASSERT_SYNC(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Condition that must never be seen while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `ASSERT_SYNC(lbl, clk, rstn, !(expr), msg)

`endif

// ===== sv/mnps_pkg.sv =====
// ----------------------------------------------------------------------------
// mnps_pkg
// Shared constants, codes and the priority compare for the note stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mnps_pkg;

    localparam int MNPS_MAX_HELD = 128;  // default held-list depth
    localparam int MNPS_NOTE_W   = 7;
    localparam int MNPS_VEL_W    = 7;
    localparam int MNPS_FUNC_W   = 2;
    localparam int MNPS_MODE_W   = 2;
    localparam int MNPS_HC_W     = 8;    // held_count port width
    localparam int MNPS_CIDX_W   = 1;
    localparam int MNPS_CDAT_W   = 2;

    typedef logic [MNPS_NOTE_W-1:0] t_note;
    typedef logic [MNPS_VEL_W-1:0]  t_vel;
    typedef logic [MNPS_FUNC_W-1:0] t_func;
    typedef logic [MNPS_MODE_W-1:0] t_mode;

    // event codes
    localparam t_func FUNC_ON  = 2'd0;
    localparam t_func FUNC_OFF = 2'd1;
    localparam t_func FUNC_ALL = 2'd2;

    // priority modes (any other code is last pressed)
    localparam t_mode PRIO_LAST = 2'd0;
    localparam t_mode PRIO_HIGH = 2'd1;
    localparam t_mode PRIO_LOW  = 2'd2;

    // config register indexes
    localparam logic [MNPS_CIDX_W-1:0] CFG_PRIORITY_MODE = 1'd0;
    localparam logic [MNPS_CIDX_W-1:0] CFG_GLIDE_ENABLED = 1'd1;

    // Fold one list entry into the running choice.
    function automatic t_note note_fold(input t_mode mode, input logic have,
                                        input t_note best, input t_note v);
        t_note res;
        res = v;
        case (mode)
            PRIO_HIGH: res = (!have || (v > best)) ? v : best;
            PRIO_LOW:  res = (!have || (v < best)) ? v : best;
            default:   res = v;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/mono_note_priority_stack.sv =====
// Sequence: note-on / note-off walk the held list (a note-on then appends), then evaluate;
//   a full list gives a note-on a second, shifting pass; all-off and unknown codes skip the walk.
// Flow: one item at a time; the walk reads one held-list RAM entry per cycle on its
//   single read port, so the list length sets how long each item takes.
// Results sit in an output register; a new item is taken while the last result still waits.
// Reset: synchronous, active low; list empty, no current note, velocities and config zero.
// ----------------------------------------------------------------------------
// mono_note_priority_stack
// Monophonic note-priority engine: held list in RAM, walked by one sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_note_priority_stack
    import mnps_pkg::*;
#(
    parameter int MAX_HELD = MNPS_MAX_HELD   // 2 .. 128
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // event channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [MNPS_FUNC_W-1:0] i_func,
    input  wire  [MNPS_NOTE_W-1:0] i_note,
    input  wire  [MNPS_VEL_W-1:0]  i_velocity,
    input  wire                    i_envelope_active,
    // result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [MNPS_NOTE_W-1:0] o_selected_note,
    output logic                   o_note_held,
    output logic                   o_new_target,
    output logic                   o_pitch_jump,
    output logic                   o_env_trigger,
    output logic                   o_env_release,
    output logic [MNPS_VEL_W-1:0]  o_gain_velocity,
    output logic [MNPS_HC_W-1:0]   o_held_count,
    // config write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [MNPS_CIDX_W-1:0] i_cfg_index,
    input  wire  [MNPS_CDAT_W-1:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_HELD + 1);   // holds 0 .. MAX_HELD
    localparam int IDX_W = $clog2(MAX_HELD);       // RAM address
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_HELD);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;  // waiting for an item
    localparam logic [1:0] S_WALK   = 2'd1;  // compaction / shift pass over the list
    localparam logic [1:0] S_APPEND = 2'd2;  // write new note at list tail
    localparam logic [1:0] S_EVAL   = 2'd3;  // pick note, update voice, load result

    // ------------------------------------------------------------------
    // Held list RAM: one write port, one registered read port.
    // Walk reads entry r while writing at w <= r - 1, so no collision.
    // ------------------------------------------------------------------
    t_note             r_mem [MAX_HELD];
    t_note             r_rdata;
    logic              w_we;
    logic [IDX_W-1:0]  w_waddr;
    t_note             w_wdata;
    logic [IDX_W-1:0]  w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // ------------------------------------------------------------------
    // Control and voice state
    // ------------------------------------------------------------------
    logic [1:0]       r_state,  n_state;
    logic [CNT_W-1:0] r_len,    n_len;     // held_len
    logic [CNT_W-1:0] r_rd,     n_rd;      // next read index
    logic [CNT_W-1:0] r_wr,     n_wr;      // next write index / kept count
    logic             r_pv,     n_pv;      // r_rdata carries a list entry
    logic             r_shift,  n_shift;   // pass drops the oldest entry
    logic             r_have,   n_have;    // r_best holds something
    t_note            r_best,   n_best;    // running priority choice

    // latched item
    t_func            r_func,   n_func;
    t_note            r_note,   n_note;
    t_vel             r_vel,    n_vel;
    logic             r_env,    n_env;

    t_note            r_cur_note,  n_cur_note;
    logic             r_cur_valid, n_cur_valid;
    t_vel             r_pend,      n_pend;     // velocity of last note-on
    t_vel             r_latch,     n_latch;    // velocity of last trigger

    t_mode            r_mode;
    logic             r_glide;

    // result register
    logic             r_out_valid, n_out_valid;
    t_note            r_o_sel,     n_o_sel;
    logic             r_o_held,    n_o_held;
    logic             r_o_tgt,     n_o_tgt;
    logic             r_o_jump,    n_o_jump;
    logic             r_o_trig,    n_o_trig;
    logic             r_o_rel,     n_o_rel;
    t_vel             r_o_gain,    n_o_gain;
    logic [MNPS_HC_W-1:0] r_o_cnt, n_o_cnt;

    logic             w_out_free;
    logic             w_keep;
    logic             w_act;
    logic             w_silent;

    assign w_raddr    = r_rd[IDX_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_keep     = r_shift || (r_rdata != r_note);
    assign w_act      = (r_func == FUNC_ON) || (r_func == FUNC_OFF) || (r_func == FUNC_ALL);
    assign w_silent   = !r_cur_valid || !r_env;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_pv        = 1'b0;
        n_shift     = r_shift;
        n_have      = r_have;
        n_best      = r_best;
        n_func      = r_func;
        n_note      = r_note;
        n_vel       = r_vel;
        n_env       = r_env;
        n_cur_note  = r_cur_note;
        n_cur_valid = r_cur_valid;
        n_pend      = r_pend;
        n_latch     = r_latch;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_sel     = r_o_sel;
        n_o_held    = r_o_held;
        n_o_tgt     = r_o_tgt;
        n_o_jump    = r_o_jump;
        n_o_trig    = r_o_trig;
        n_o_rel     = r_o_rel;
        n_o_gain    = r_o_gain;
        n_o_cnt     = r_o_cnt;
        w_we        = 1'b0;
        w_waddr     = r_wr[IDX_W-1:0];
        w_wdata     = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_note  = i_note;
                    n_vel   = i_velocity;
                    n_env   = i_envelope_active;
                    n_rd    = '0;
                    n_wr    = '0;
                    n_have  = 1'b0;
                    n_shift = 1'b0;
                    case (i_func)
                        FUNC_ON, FUNC_OFF: begin
                            n_state = S_WALK;
                        end
                        FUNC_ALL: begin
                            n_len   = '0;
                            n_state = S_EVAL;
                        end
                        default: begin
                            n_state = S_EVAL;   // unknown code: report only
                        end
                    endcase
                end
            end

            S_WALK: begin
                // consume the entry read last cycle
                if (r_pv && w_keep) begin
                    w_we   = 1'b1;
                    n_wr   = r_wr + 1'b1;
                    n_best = note_fold(r_mode, r_have, r_best, r_rdata);
                    n_have = 1'b1;
                end
                if (r_rd != r_len) begin
                    n_rd = r_rd + 1'b1;
                    n_pv = 1'b1;
                end else if (!r_pv) begin
                    n_len = r_wr;
                    if (r_func == FUNC_ON) begin
                        if (r_wr == FULL_CNT) begin
                            // full list: second pass moves entries down by one
                            n_shift = 1'b1;
                            n_rd    = CNT_W'(1);
                            n_wr    = '0;
                            n_have  = 1'b0;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end else begin
                        n_state = S_EVAL;
                    end
                end
            end

            S_APPEND: begin
                w_we    = 1'b1;
                w_wdata = r_note;
                n_len   = r_wr + 1'b1;
                n_best  = note_fold(r_mode, r_have, r_best, r_note);
                n_have  = 1'b1;
                n_pend  = r_vel;
                n_state = S_EVAL;
            end

            S_EVAL: begin
                if (w_out_free) begin
                    n_o_tgt  = 1'b0;
                    n_o_jump = 1'b0;
                    n_o_trig = 1'b0;
                    n_o_rel  = 1'b0;
                    if (w_act) begin
                        if (r_len == '0) begin
                            if (r_cur_valid) begin
                                n_o_rel = 1'b1;
                            end
                            n_cur_valid = 1'b0;
                            n_cur_note  = '0;
                        end else if (w_silent || (r_best != r_cur_note)) begin
                            n_o_tgt     = 1'b1;
                            n_o_jump    = w_silent || !r_glide;
                            n_cur_note  = r_best;
                            n_cur_valid = 1'b1;
                            if (w_silent && (r_func == FUNC_ON)) begin
                                n_o_trig = 1'b1;
                                n_latch  = r_pend;
                            end
                        end
                    end
                    n_o_sel     = n_cur_valid ? n_cur_note : '0;
                    n_o_held    = n_cur_valid;
                    n_o_gain    = n_latch;
                    n_o_cnt     = MNPS_HC_W'(r_len);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_pv        <= 1'b0;
            r_cur_note  <= '0;
            r_cur_valid <= 1'b0;
            r_pend      <= '0;
            r_latch     <= '0;
            r_mode      <= PRIO_LAST;
            r_glide     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_pv        <= n_pv;
            r_cur_note  <= n_cur_note;
            r_cur_valid <= n_cur_valid;
            r_pend      <= n_pend;
            r_latch     <= n_latch;
            r_out_valid <= n_out_valid;
            // the user must send config only while idle; the block itself does not enforce it
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PRIORITY_MODE: r_mode  <= i_cfg_data;
                    CFG_GLIDE_ENABLED: r_glide <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // walk datapath and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_rd    <= n_rd;
        r_wr    <= n_wr;
        r_shift <= n_shift;
        r_have  <= n_have;
        r_best  <= n_best;
        r_func  <= n_func;
        r_note  <= n_note;
        r_vel   <= n_vel;
        r_env   <= n_env;
        r_o_sel  <= n_o_sel;
        r_o_held <= n_o_held;
        r_o_tgt  <= n_o_tgt;
        r_o_jump <= n_o_jump;
        r_o_trig <= n_o_trig;
        r_o_rel  <= n_o_rel;
        r_o_gain <= n_o_gain;
        r_o_cnt  <= n_o_cnt;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_selected_note = r_o_sel;
    assign o_note_held     = r_o_held;
    assign o_new_target    = r_o_tgt;
    assign o_pitch_jump    = r_o_jump;
    assign o_env_trigger   = r_o_trig;
    assign o_env_release   = r_o_rel;
    assign o_gain_velocity = r_o_gain;
    assign o_held_count    = r_o_cnt;

endmodule

`default_nettype wire

// ===== sv/mnps_checker.sv =====
// ----------------------------------------------------------------------------
// mnps_port_checker
// Port-level checks on the note stack, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mnps_port_checker
    import mnps_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   o_in_stall,
    input wire                   o_out_valid,
    input wire                   i_out_stall,
    input wire [MNPS_NOTE_W-1:0] o_selected_note,
    input wire                   o_note_held,
    input wire                   o_new_target,
    input wire                   o_pitch_jump,
    input wire                   o_env_trigger,
    input wire                   o_env_release,
    input wire [MNPS_VEL_W-1:0]  o_gain_velocity,
    input wire [MNPS_HC_W-1:0]   o_held_count
);

    // busy right after taking an item
    `ASSERT_SYNC(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && !o_in_stall) |=> o_in_stall, "not busy after item accept")

    // stalled result holds
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_selected_note)
            && $stable(o_held_count) && $stable(o_gain_velocity)), "stalled result changed")

    // a trigger is always a jump to a new held target
    `ASSERT_NEVER(a_trig_jump, i_clk, i_rst_n,
        o_out_valid && o_env_trigger && !(o_new_target && o_pitch_jump && o_note_held),
        "trigger without jump to target")

    // release only with an empty list
    `ASSERT_NEVER(a_rel_empty, i_clk, i_rst_n,
        o_out_valid && o_env_release && (o_note_held || o_new_target || o_held_count != 0),
        "release with notes held")

    // a note sounds exactly when the list is not empty
    `ASSERT_SYNC(a_held_count, i_clk, i_rst_n,
        o_out_valid |-> (o_note_held == (o_held_count != 0)), "note_held and count disagree")

endmodule

bind mono_note_priority_stack mnps_port_checker u_mnps_port_checker (.*);

`default_nettype wire

// ===== verif/mnps_checker.sv =====
// ----------------------------------------------------------------------------
// mnps_checker
// Watches the event, result and config channels of the note stack, keeps its
// own copy of the held list and voice state, and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mnps_checker
    import mnps_pkg::*;
#(
    parameter int MAX_HELD = MNPS_MAX_HELD
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // event channel
    input  wire                    i_in_valid,
    input  wire                    i_in_stall,
    input  wire  [MNPS_FUNC_W-1:0] i_func,
    input  wire  [MNPS_NOTE_W-1:0] i_note,
    input  wire  [MNPS_VEL_W-1:0]  i_velocity,
    input  wire                    i_envelope_active,
    // result channel
    input  wire                    i_out_valid,
    input  wire                    i_out_stall,
    input  wire  [MNPS_NOTE_W-1:0] i_selected_note,
    input  wire                    i_note_held,
    input  wire                    i_new_target,
    input  wire                    i_pitch_jump,
    input  wire                    i_env_trigger,
    input  wire                    i_env_release,
    input  wire  [MNPS_VEL_W-1:0]  i_gain_velocity,
    input  wire  [MNPS_HC_W-1:0]   i_held_count,
    // config channel
    input  wire                    i_cfg_valid,
    input  wire                    i_cfg_ready,
    input  wire  [MNPS_CIDX_W-1:0] i_cfg_index,
    input  wire  [MNPS_CDAT_W-1:0] i_cfg_data,
    // to the top
    output int                     o_fail_count,
    output int                     o_outstanding
);

    typedef struct packed {
        t_note                sel;
        logic                 held;
        logic                 tgt;
        logic                 jump;
        logic                 trig;
        logic                 rel;
        t_vel                 gain;
        logic [MNPS_HC_W-1:0] held_count;
    } t_voice_result;

    // voice state, press order kept oldest first
    t_note         held_notes [MAX_HELD];
    int            held_len;
    t_note         cur_note;
    logic          cur_valid;
    t_vel          pend_vel;
    t_vel          gain_vel;
    t_mode         prio_mode;
    logic          glide_on;

    t_voice_result voice_q [$];
    int            fails = 0;

    function automatic void remove_note(input t_note n);
        int rd;
        int wr;
        wr = 0;
        for (rd = 0; rd < held_len; rd++) begin
            if (held_notes[rd] != n) begin
                held_notes[wr] = held_notes[rd];
                wr++;
            end
        end
        held_len = wr;
    endfunction

    function automatic t_note pick_note();
        t_note best;
        int    i;
        best = held_notes[held_len-1];
        if (prio_mode == PRIO_HIGH || prio_mode == PRIO_LOW) begin
            best = held_notes[0];
            for (i = 1; i < held_len; i++) begin
                if (prio_mode == PRIO_HIGH ? (held_notes[i] > best) : (held_notes[i] < best))
                    best = held_notes[i];
            end
        end
        return best;
    endfunction

    function automatic t_voice_result apply_event(input t_func f, input t_note n,
                                                  input t_vel v, input logic env);
        t_voice_result r;
        t_note         pick;
        logic          silent;
        int            i;
        r = '0;
        if (f == FUNC_ON || f == FUNC_OFF || f == FUNC_ALL) begin
            if (f == FUNC_ON) begin
                remove_note(n);
                if (held_len >= MAX_HELD) begin
                    // full list: oldest entry goes
                    for (i = 0; i < MAX_HELD - 1; i++)
                        held_notes[i] = held_notes[i+1];
                    held_len = MAX_HELD - 1;
                end
                held_notes[held_len] = n;
                held_len++;
                pend_vel = v;
            end else if (f == FUNC_OFF) begin
                remove_note(n);
            end else begin
                held_len = 0;
            end

            if (held_len == 0) begin
                if (cur_valid) begin
                    r.rel     = 1'b1;
                    cur_valid = 1'b0;
                    cur_note  = '0;
                end
            end else begin
                pick   = pick_note();
                silent = !cur_valid || !env;
                if (silent || pick != cur_note) begin
                    r.tgt     = 1'b1;
                    r.jump    = silent || !glide_on;
                    cur_note  = pick;
                    cur_valid = 1'b1;
                    if (silent && f == FUNC_ON) begin
                        r.trig   = 1'b1;
                        gain_vel = pend_vel;
                    end
                end
            end
        end
        r.sel        = cur_valid ? cur_note : '0;
        r.held       = cur_valid;
        r.gain       = gain_vel;
        r.held_count = held_len[MNPS_HC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_voice_result got;
        t_voice_result want;
        if (!i_rst_n) begin
            held_len  = 0;
            cur_note  = '0;
            cur_valid = 1'b0;
            pend_vel  = '0;
            gain_vel  = '0;
            prio_mode = PRIO_LAST;
            glide_on  = 1'b0;
            voice_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRIORITY_MODE: prio_mode = i_cfg_data;
                    CFG_GLIDE_ENABLED: glide_on  = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                got = '{i_selected_note, i_note_held, i_new_target, i_pitch_jump,
                        i_env_trigger, i_env_release, i_gain_velocity, i_held_count};
                if (voice_q.size() == 0) begin
                    if (fails < 10)
                        $display("%0t: result item with nothing pending", $realtime);
                    fails++;
                end else begin
                    want = voice_q.pop_front();
                    if (got !== want) begin
                        if (fails < 10) begin
                            $display("%0t: mismatch note/held/tgt/jump/trig/rel/gain/count",
                                     $realtime);
                            $display("  exp %0d/%0b/%0b/%0b/%0b/%0b/%0d/%0d",
                                     want.sel, want.held, want.tgt, want.jump, want.trig,
                                     want.rel, want.gain, want.held_count);
                            $display("  got %0d/%0b/%0b/%0b/%0b/%0b/%0d/%0d",
                                     got.sel, got.held, got.tgt, got.jump, got.trig,
                                     got.rel, got.gain, got.held_count);
                        end
                        fails++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall)
                voice_q.insert(voice_q.size(),
                               apply_event(i_func, i_note, i_velocity, i_envelope_active));
        end
        o_fail_count  <= fails;
        o_outstanding <= voice_q.size();
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the note-priority stack: directed events, then random
// phrases under every priority mode with random glide, with random idling on both
// channels and one long result hold-off. Checking is in mnps_checker and mnps_port_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mnps_pkg::*;

    // Block runs at its default depth; a note-on removes its own note first,
    // so with 128 entries every note number fits and the list never overflows.
    localparam int    HELD_DEPTH     = MNPS_MAX_HELD;
    localparam int    BURST_PRESSES  = 24;
    localparam int    LONG_HOLD      = 400;
    localparam int    WALK_CYCLES    = 2 * HELD_DEPTH + 6;
    localparam int    WATCHDOG_LIMIT = 4 * (LONG_HOLD + WALK_CYCLES + HELD_DEPTH + 13);
    localparam int    TAIL_CYCLES    = 2 * WALK_CYCLES;
    localparam int    RAND_PHASES    = 11;
    localparam int    PHASE_ITEMS    = 90;

    // codes the block must tolerate but the package leaves unnamed
    localparam t_func FUNC_UNKNOWN   = 2'd3;
    localparam t_mode PRIO_UNKNOWN   = 2'd3;

    logic                   i_clk;
    logic                   i_rst_n           = 1'b0;
    logic                   i_in_valid        = 1'b0;
    logic [MNPS_FUNC_W-1:0] i_func            = FUNC_ON;
    logic [MNPS_NOTE_W-1:0] i_note            = '0;
    logic [MNPS_VEL_W-1:0]  i_velocity        = '0;
    logic                   i_envelope_active = 1'b0;
    logic                   i_out_stall       = 1'b0;
    logic                   i_cfg_valid       = 1'b0;
    logic [MNPS_CIDX_W-1:0] i_cfg_index       = CFG_PRIORITY_MODE;
    logic [MNPS_CDAT_W-1:0] i_cfg_data        = '0;

    wire                    o_in_stall;
    wire                    o_out_valid;
    wire [MNPS_NOTE_W-1:0]  o_selected_note;
    wire                    o_note_held;
    wire                    o_new_target;
    wire                    o_pitch_jump;
    wire                    o_env_trigger;
    wire                    o_env_release;
    wire [MNPS_VEL_W-1:0]   o_gain_velocity;
    wire [MNPS_HC_W-1:0]    o_held_count;
    wire                    o_cfg_ready;

    int                     chk_fails;
    int                     chk_outstanding;

    logic                   quiet         = 1'b0;  // no idling in the closing phases
    logic                   long_hold_req = 1'b0;  // ask the sink for one long hold-off
    int                     idle_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    mono_note_priority_stack #(
        .MAX_HELD(HELD_DEPTH)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_note            (i_note),
        .i_velocity        (i_velocity),
        .i_envelope_active (i_envelope_active),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_selected_note   (o_selected_note),
        .o_note_held       (o_note_held),
        .o_new_target      (o_new_target),
        .o_pitch_jump      (o_pitch_jump),
        .o_env_trigger     (o_env_trigger),
        .o_env_release     (o_env_release),
        .o_gain_velocity   (o_gain_velocity),
        .o_held_count      (o_held_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    mnps_checker #(
        .MAX_HELD(HELD_DEPTH)
    ) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_func            (i_func),
        .i_note            (i_note),
        .i_velocity        (i_velocity),
        .i_envelope_active (i_envelope_active),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_selected_note   (o_selected_note),
        .i_note_held       (o_note_held),
        .i_new_target      (o_new_target),
        .i_pitch_jump      (o_pitch_jump),
        .i_env_trigger     (o_env_trigger),
        .i_env_release     (o_env_release),
        .i_gain_velocity   (o_gain_velocity),
        .i_held_count      (o_held_count),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (chk_fails),
        .o_outstanding     (chk_outstanding)
    );

    // Offer one event and return at the edge that takes it. Valid stays high
    // on return, so back-to-back events keep it up unless the random idling drops it.
    task automatic send_event(input t_func f, input t_note n, input t_vel v,
                              input logic env);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= f;
        i_note            <= n;
        i_velocity        <= v;
        i_envelope_active <= env;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait until every pending result item has been seen.
    // The checker count is registered, hence the edge before the first look.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (chk_outstanding != 0);
    endtask

    // Both registers, one after the other; only called with the block idle.
    task automatic write_config(input t_mode mode, input logic [MNPS_CDAT_W-1:0] glide);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PRIORITY_MODE;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_GLIDE_ENABLED;
        i_cfg_data  <= glide;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Random playing: mostly presses and releases of notes that are actually
    // down, inside a note window, plus stray releases, all-offs and unknown
    // codes. Halfway through, a run of presses builds a long list.
    task automatic random_phase(input int count, input int span);
        t_note pressed [$];
        t_note base;
        t_note n;
        t_func f;
        int    k;
        int    j;
        int    roll;
        int    pick;
        base = t_note'($urandom_range(0, 127));
        for (k = 0; k < count; k++) begin
            if (k == count / 2) begin
                for (j = 0; j < BURST_PRESSES; j++) begin
                    n = t_note'($urandom_range(0, 127));
                    pressed.insert(pressed.size(), n);
                    send_event(FUNC_ON, n, t_vel'($urandom_range(0, 127)),
                               $urandom_range(0, 4) != 0);
                end
            end
            roll = int'($urandom_range(0, 99));
            f    = FUNC_ON;
            n    = t_note'(base + $urandom_range(0, span));   // wraps inside 7 bits
            if (roll < 35 && pressed.size() != 0) begin
                f    = FUNC_OFF;
                pick = int'($urandom_range(0, pressed.size() - 1));
                n    = pressed[pick];
                pressed.delete(pick);
            end else if (roll >= 35 && roll < 40) begin
                f = FUNC_OFF;                       // most likely not held
            end else if (roll >= 40 && roll < 44) begin
                f = FUNC_ALL;
                pressed.delete();
            end else if (roll >= 44 && roll < 47) begin
                f = FUNC_UNKNOWN;
            end
            if (f == FUNC_ON)
                pressed.insert(pressed.size(), n);
            send_event(f, n, t_vel'($urandom_range(0, 127)), $urandom_range(0, 4) != 0);
        end
    endtask

    // Result sink: random stall bursts, one long hold-off on request so the
    // block backs up and stalls its event side, none once things go quiet.
    initial begin : result_sink
        logic long_done;
        long_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !long_done) begin
                long_done   = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: ends the run when no channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        int p;
        int span;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // last pressed, no glide (upper data bit set, must be ignored)
        write_config(PRIO_LAST, 2'b10);
        send_event(FUNC_OFF, 7'd5, 7'd0, 1'b1);          // release on empty list
        send_event(FUNC_ALL, 7'd0, 7'd0, 1'b1);          // all-off on empty list
        send_event(FUNC_UNKNOWN, 7'd0, 7'd0, 1'b0);      // unknown code, idle voice
        send_event(FUNC_ON, 7'd0, 7'd127, 1'b0);         // silent press: trigger
        send_event(FUNC_ON, 7'd127, 7'd0, 1'b1);         // new target, jump
        send_event(FUNC_ON, 7'd127, 7'd64, 1'b1);        // re-press of the same note
        send_event(FUNC_ON, 7'd60, 7'd33, 1'b0);         // envelope done: retrigger
        send_event(FUNC_OFF, 7'd99, 7'd0, 1'b1);         // release of an unheld note
        send_event(FUNC_UNKNOWN, 7'd127, 7'd127, 1'b1);  // unknown code, voice sounding
        send_event(FUNC_OFF, 7'd60, 7'd0, 1'b1);
        send_event(FUNC_OFF, 7'd127, 7'd0, 1'b1);
        send_event(FUNC_OFF, 7'd0, 7'd0, 1'b1);          // list empties: release
        send_event(FUNC_OFF, 7'd0, 7'd0, 1'b1);
        drain();

        // highest note, glide on
        write_config(PRIO_HIGH, 2'b01);
        send_event(FUNC_ON, 7'd10, 7'd100, 1'b0);
        send_event(FUNC_ON, 7'd90, 7'd1, 1'b1);          // glides up
        send_event(FUNC_ON, 7'd40, 7'd2, 1'b1);          // lower press: no move
        send_event(FUNC_OFF, 7'd90, 7'd0, 1'b1);         // falls back to 40
        drain();

        // lowest note
        write_config(PRIO_LOW, 2'b11);
        send_event(FUNC_ON, 7'd5, 7'd7, 1'b1);
        send_event(FUNC_ON, 7'd2, 7'd8, 1'b1);
        send_event(FUNC_ALL, 7'd0, 7'd0, 1'b1);          // release of the whole list
        drain();

        // unknown priority code behaves as last pressed
        write_config(PRIO_UNKNOWN, 2'b00);
        send_event(FUNC_ON, 7'd30, 7'd90, 1'b0);
        send_event(FUNC_ON, 7'd20, 7'd91, 1'b1);
        send_event(FUNC_OFF, 7'd20, 7'd0, 1'b1);
        drain();

        for (p = 0; p < RAND_PHASES; p++) begin
            case (p % 3)
                0:       span = 7;
                1:       span = 31;
                default: span = 127;
            endcase
            write_config(p[MNPS_MODE_W-1:0], MNPS_CDAT_W'($urandom_range(0, 3)));
            if (p == 2)
                long_hold_req <= 1'b1;
            if (p == RAND_PHASES - 2)
                quiet <= 1'b1;
            random_phase(PHASE_ITEMS, span);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk_fails == 0 && chk_outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
